>>> sv/ohlc_bar_aggregator_unit_defines.svh
// Assertion macros shared by the aggregator RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef OHLC_BAR_AGGREGATOR_UNIT_DEFINES_SVH
`define OHLC_BAR_AGGREGATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define OHLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OHLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ohlc_pkg.sv
`timescale 1ns / 1ps
package ohlc_pkg;

  // Field widths
  localparam int DateW  = 27;
  localparam int SeqW   = 15;
  localparam int PriceW = 32;
  localparam int DivW   = 16;
  localparam int GapW   = 15;

  // Divider geometry: dividend 2P+d, divisor 2d
  localparam int DvdW     = PriceW + 2;
  localparam int DvsW     = DivW + 1;
  localparam int DivSteps = DvdW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  // Group marker backoff
  localparam int MarkW = 16;
  localparam logic [MarkW-1:0] SeqBackoff = 16'd5;

  // Register reset values
  localparam logic [DivW-1:0] ScaleReset = 16'd1;
  localparam logic [GapW-1:0] GapReset   = 15'd30;

  // Price slots in the operand buffer
  localparam logic [1:0] SlotOpen  = 2'd0;
  localparam logic [1:0] SlotHigh  = 2'd1;
  localparam logic [1:0] SlotLow   = 2'd2;
  localparam logic [1:0] SlotClose = 2'd3;

  typedef enum logic [0:0] {
    CFG_SCALE_DIV = 1'b0,
    CFG_GAP_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_START      = 6'b000010,
    S_DIV        = 6'b000100,
    S_MERGE      = 6'b001000,
    S_EMIT_GROUP = 6'b010000,
    S_UPDATE     = 6'b100000
  } agg_state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/ohlc_div.sv
`timescale 1ns / 1ps
module ohlc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ohlc_pkg::DvdW-1:0]   dividend_i,
  input  logic [ohlc_pkg::DvsW-1:0]   divisor_i,
  output ohlc_pkg::div_stat_t         stat_o,
  output logic [ohlc_pkg::PriceW-1:0] quotient_o
);
  import ohlc_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW-1:0]    rem_q, dvs_q;
  logic [DvdW-1:0]    num_q;
  logic [PriceW-1:0]  quo_q;
  logic [DvsW:0]      trial;
  logic               fits;

  // One restoring step: bring down the next dividend bit and try subtract
  assign trial = {rem_q, num_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift remainder, dividend and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      num_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      num_q <= {num_q[DvdW-2:0], 1'b0};
      quo_q <= {quo_q[PriceW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> sv/ohlc_bar_aggregator_unit.sv
`timescale 1ns / 1ps
// OHLC bar aggregator: merges fine price bars into coarse bars.
// Input channel (in_valid_i/in_ready_o) takes one fine bar per item; the
// output channel (out_valid_o/out_ready_i) returns finished coarse bars.
// A fine bar yields zero, one or two coarse bars: the finished bar when a
// new bar starts, then the flushed bar when final_item_i is set.
// Configuration (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
// the price divisor (index 0) and the sequence gap limit (index 1); it is
// always ready and should be written only while the block is idle.
// The pace of items is set by the single bit-serial divider that scales
// the four prices one after another (34 steps plus a load and a handoff
// step each). Results are registered onto out_valid_o; a flushed bar that
// follows a finished bar is loaded once the output register is free again.
// The input is not ready while an item is in work. A stalled receiver
// holds the output register; the block then waits before loading the next
// result but still accepts a new item once the current one is finished.
// Reset clears all bar state, sets the divisor to 1 and the gap to 30.
// After a final item all bar state returns to reset; registers are kept.
module ohlc_bar_aggregator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  ohlc_pkg::cfg_idx_e          cfg_index_i,
  input  logic [ohlc_pkg::DivW-1:0]   cfg_data_i,
  // fine bars in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ohlc_pkg::DateW-1:0]  bar_date_i,
  input  logic [ohlc_pkg::SeqW-1:0]   time_seq_i,
  input  logic [ohlc_pkg::PriceW-1:0] open_price_i,
  input  logic [ohlc_pkg::PriceW-1:0] high_price_i,
  input  logic [ohlc_pkg::PriceW-1:0] low_price_i,
  input  logic [ohlc_pkg::PriceW-1:0] close_price_i,
  input  logic                        final_item_i,
  // coarse bars out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ohlc_pkg::DateW-1:0]  out_date_o,
  output logic [ohlc_pkg::SeqW-1:0]   out_seq_o,
  output logic [ohlc_pkg::PriceW-1:0] out_open_o,
  output logic [ohlc_pkg::PriceW-1:0] out_high_o,
  output logic [ohlc_pkg::PriceW-1:0] out_low_o,
  output logic [ohlc_pkg::PriceW-1:0] out_close_o,
  output logic [ohlc_pkg::PriceW-1:0] first_fine_index_o,
  output logic [ohlc_pkg::PriceW-1:0] coarse_index_o,
  output logic [ohlc_pkg::PriceW-1:0] overall_high_o,
  output logic [ohlc_pkg::PriceW-1:0] overall_low_o,
  output logic                        stream_end_o
);
  import ohlc_pkg::*;

  agg_state_e state_q, state_d;

  // Registers
  logic [DivW-1:0] scale_q;
  logic [GapW-1:0] gap_q;

  // Latched item
  logic [DateW-1:0]  date_q;
  logic [SeqW-1:0]   seq_q;
  logic              final_q;
  logic [PriceW-1:0] price_q [4];
  logic [1:0]        slot_q;
  logic              start_q;

  // Bar state
  logic              grp_open_q;
  logic [DateW-1:0]  grp_date_q;
  logic [MarkW-1:0]  grp_mark_q;
  logic [SeqW-1:0]   grp_seq_q;
  logic [PriceW-1:0] grp_op_q, grp_hi_q, grp_lo_q, grp_cl_q, grp_idx_q;
  logic [PriceW-1:0] fine_cnt_q, coarse_cnt_q, strm_hi_q, strm_lo_q;

  // Output register
  logic              out_valid_q;
  logic [DateW-1:0]  o_date_q;
  logic [SeqW-1:0]   o_seq_q;
  logic [PriceW-1:0] o_op_q, o_hi_q, o_lo_q, o_cl_q, o_idx_q, o_cnt_q, o_shi_q, o_slo_q;
  logic              o_end_q;

  logic              in_fire, out_free, emit_group, emit_final;
  logic [DivW-1:0]   dvs_eff;
  logic [DvdW-1:0]   dividend;
  logic [DvsW-1:0]   divisor;
  div_stat_t         div_stat;
  logic [PriceW-1:0] quotient;
  logic signed [SeqW+2:0] seq_span;
  logic              start_now;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_group  = (state_q == S_EMIT_GROUP) && out_free;
  assign emit_final  = (state_q == S_UPDATE) && final_q && out_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      gap_q   <= GapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALE_DIV: scale_q <= cfg_data_i;
        CFG_GAP_LIMIT: gap_q   <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  // Build divider operands: (2P + d) / (2d), zero divisor taken as one
  assign dvs_eff  = (scale_q == '0) ? DivW'(1) : scale_q;
  assign divisor  = {dvs_eff, 1'b0};
  assign dividend = {1'b0, price_q[slot_q], 1'b0} + DvdW'(dvs_eff);

  ohlc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Decide whether this item opens a new bar
  assign seq_span = $signed({3'b000, seq_q}) - $signed({{(SeqW+3-MarkW){grp_mark_q[MarkW-1]}},
                                                         grp_mark_q});
  assign start_now = !grp_open_q || (date_q != grp_date_q) ||
                     (seq_span > $signed({3'b000, gap_q}));

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_fire) state_d = S_START;
      S_START:      state_d = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_d = (slot_q == SlotClose) ? S_MERGE : S_START;
        end
      end
      S_MERGE:      state_d = (start_now && grp_open_q) ? S_EMIT_GROUP : S_UPDATE;
      S_EMIT_GROUP: if (out_free) state_d = S_UPDATE;
      S_UPDATE:     if (!final_q || out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= SlotOpen;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        slot_q <= SlotOpen;
      end else if (state_q == S_DIV && div_stat.done) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Latch the item, then overwrite each price with its scaled value
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      date_q     <= bar_date_i;
      seq_q      <= time_seq_i;
      final_q    <= final_item_i;
      price_q[0] <= open_price_i;
      price_q[1] <= high_price_i;
      price_q[2] <= low_price_i;
      price_q[3] <= close_price_i;
    end else if (state_q == S_DIV && div_stat.done) begin
      price_q[slot_q] <= quotient;
    end
    if (state_q == S_MERGE) begin
      start_q <= start_now;
    end
  end

  // Update bar state, counters and stream extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_open_q   <= 1'b0;
      grp_date_q   <= '0;
      grp_mark_q   <= '0;
      grp_seq_q    <= '0;
      grp_op_q     <= '0;
      grp_hi_q     <= '0;
      grp_lo_q     <= '0;
      grp_cl_q     <= '0;
      grp_idx_q    <= '0;
      fine_cnt_q   <= '0;
      coarse_cnt_q <= '0;
      strm_hi_q    <= '0;
      strm_lo_q    <= '1;
    end else begin
      if (state_q == S_MERGE) begin
        if (price_q[SlotHigh] > strm_hi_q) strm_hi_q <= price_q[SlotHigh];
        if (price_q[SlotLow] < strm_lo_q)  strm_lo_q <= price_q[SlotLow];
      end
      if (emit_group) begin
        coarse_cnt_q <= coarse_cnt_q + 1'b1;
      end
      if (emit_final) begin
        // final flush: drop all bar state back to reset
        grp_open_q   <= 1'b0;
        grp_date_q   <= '0;
        grp_mark_q   <= '0;
        grp_seq_q    <= '0;
        grp_op_q     <= '0;
        grp_hi_q     <= '0;
        grp_lo_q     <= '0;
        grp_cl_q     <= '0;
        grp_idx_q    <= '0;
        fine_cnt_q   <= '0;
        coarse_cnt_q <= '0;
        strm_hi_q    <= '0;
        strm_lo_q    <= '1;
      end else if (state_q == S_UPDATE && !final_q) begin
        if (start_q) begin
          grp_open_q <= 1'b1;
          grp_date_q <= date_q;
          grp_mark_q <= {1'b0, seq_q} - SeqBackoff;
          grp_op_q   <= price_q[SlotOpen];
          grp_hi_q   <= price_q[SlotHigh];
          grp_lo_q   <= price_q[SlotLow];
          grp_idx_q  <= fine_cnt_q;
        end else begin
          if (price_q[SlotHigh] > grp_hi_q) grp_hi_q <= price_q[SlotHigh];
          if (price_q[SlotLow] < grp_lo_q)  grp_lo_q <= price_q[SlotLow];
        end
        grp_cl_q   <= price_q[SlotClose];
        grp_seq_q  <= seq_q;
        fine_cnt_q <= fine_cnt_q + 1'b1;
      end
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_group || emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the finished bar, or the flushed bar merged with this item
  always_ff @(posedge clk_i) begin
    if (emit_group) begin
      o_date_q <= grp_date_q;
      o_seq_q  <= grp_seq_q;
      o_op_q   <= grp_op_q;
      o_hi_q   <= grp_hi_q;
      o_lo_q   <= grp_lo_q;
      o_cl_q   <= grp_cl_q;
      o_idx_q  <= grp_idx_q;
      o_cnt_q  <= coarse_cnt_q;
      o_shi_q  <= '0;
      o_slo_q  <= '0;
      o_end_q  <= 1'b0;
    end else if (emit_final) begin
      o_date_q <= start_q ? date_q : grp_date_q;
      o_seq_q  <= seq_q;
      o_op_q   <= start_q ? price_q[SlotOpen] : grp_op_q;
      o_hi_q   <= (!start_q && grp_hi_q >= price_q[SlotHigh]) ? grp_hi_q
                                                              : price_q[SlotHigh];
      o_lo_q   <= (!start_q && grp_lo_q <= price_q[SlotLow]) ? grp_lo_q
                                                             : price_q[SlotLow];
      o_cl_q   <= price_q[SlotClose];
      o_idx_q  <= start_q ? fine_cnt_q : grp_idx_q;
      o_cnt_q  <= coarse_cnt_q;
      o_shi_q  <= strm_hi_q;
      o_slo_q  <= strm_lo_q;
      o_end_q  <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_date_o         = o_date_q;
  assign out_seq_o          = o_seq_q;
  assign out_open_o         = o_op_q;
  assign out_high_o         = o_hi_q;
  assign out_low_o          = o_lo_q;
  assign out_close_o        = o_cl_q;
  assign first_fine_index_o = o_idx_q;
  assign coarse_index_o     = o_cnt_q;
  assign overall_high_o     = o_shi_q;
  assign overall_low_o      = o_slo_q;
  assign stream_end_o       = o_end_q;

  `include "ohlc_bar_aggregator_unit_defines.svh"

  `OHLC_ASSERT_SAME(a_idle_div_quiet, state_q == S_IDLE, !div_stat.busy, "divider busy while idle")
  `OHLC_ASSERT_SAME(a_done_in_div, div_stat.done, state_q == S_DIV, "divider done outside wait")
  `OHLC_ASSERT_SAME(a_mid_zero_ext, out_valid_o && !stream_end_o, overall_high_o == '0 && overall_low_o == '0, "extremes on a mid-stream bar")
  `OHLC_ASSERT_NEXT(a_flush_clears, emit_final, !grp_open_q && fine_cnt_q == '0 && coarse_cnt_q == '0, "state kept after flush")

endmodule

>>> tb/sv/ohlc_bar_aggregator_unit_test.sv
`timescale 1ns / 1ps
module ohlc_bar_aggregator_unit_test;
  import ohlc_pkg::*;

  // One fine bar as driven on the input channel
  typedef struct {
    logic [DateW-1:0]  date;
    logic [SeqW-1:0]   seq;
    logic [PriceW-1:0] op_px;
    logic [PriceW-1:0] hi_px;
    logic [PriceW-1:0] lo_px;
    logic [PriceW-1:0] cl_px;
    logic              last;
  } fine_bar_t;

  // One coarse bar as seen on the output channel
  typedef struct {
    logic [DateW-1:0]  date;
    logic [SeqW-1:0]   seq;
    logic [PriceW-1:0] op_px;
    logic [PriceW-1:0] hi_px;
    logic [PriceW-1:0] lo_px;
    logic [PriceW-1:0] cl_px;
    logic [PriceW-1:0] first_idx;
    logic [PriceW-1:0] coarse_idx;
    logic [PriceW-1:0] total_hi;
    logic [PriceW-1:0] total_lo;
    logic              stream_end;
  } coarse_bar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i = CFG_SCALE_DIV;
  logic [DivW-1:0]      cfg_data_i = '0;

  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [DateW-1:0]     bar_date_i = '0;
  logic [SeqW-1:0]      time_seq_i = '0;
  logic [PriceW-1:0]    open_price_i = '0;
  logic [PriceW-1:0]    high_price_i = '0;
  logic [PriceW-1:0]    low_price_i = '0;
  logic [PriceW-1:0]    close_price_i = '0;
  logic                 final_item_i = 1'b0;

  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DateW-1:0]     out_date_o;
  logic [SeqW-1:0]      out_seq_o;
  logic [PriceW-1:0]    out_open_o;
  logic [PriceW-1:0]    out_high_o;
  logic [PriceW-1:0]    out_low_o;
  logic [PriceW-1:0]    out_close_o;
  logic [PriceW-1:0]    first_fine_index_o;
  logic [PriceW-1:0]    coarse_index_o;
  logic [PriceW-1:0]    overall_high_o;
  logic [PriceW-1:0]    overall_low_o;
  logic                 stream_end_o;

  ohlc_bar_aggregator_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .bar_date_i         (bar_date_i),
    .time_seq_i         (time_seq_i),
    .open_price_i       (open_price_i),
    .high_price_i       (high_price_i),
    .low_price_i        (low_price_i),
    .close_price_i      (close_price_i),
    .final_item_i       (final_item_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_date_o         (out_date_o),
    .out_seq_o          (out_seq_o),
    .out_open_o         (out_open_o),
    .out_high_o         (out_high_o),
    .out_low_o          (out_low_o),
    .out_close_o        (out_close_o),
    .first_fine_index_o (first_fine_index_o),
    .coarse_index_o     (coarse_index_o),
    .overall_high_o     (overall_high_o),
    .overall_low_o      (overall_low_o),
    .stream_end_o       (stream_end_o)
  );

  // Clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  fine_bar_t   bar_backlog[$];
  fine_bar_t   bar_on_wire;
  coarse_bar_t coarse_expected[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_count = 0;

  // Shadow registers
  logic [DivW-1:0] price_div = ScaleReset;
  logic [GapW-1:0] seq_gap = GapReset;

  // Shadow bar state
  logic              bar_open;
  logic [DateW-1:0]  bar_day;
  logic [MarkW-1:0]  bar_marker;
  logic [SeqW-1:0]   bar_last_seq;
  logic [PriceW-1:0] bar_op, bar_hi, bar_lo, bar_cl;
  logic [PriceW-1:0] bar_first_idx;
  logic [PriceW-1:0] fine_total;
  logic [PriceW-1:0] coarse_total;
  logic [PriceW-1:0] session_hi;
  logic [PriceW-1:0] session_lo;

  // Return all bar state to its reset value
  function automatic void clear_bar_state();
    bar_open = 1'b0;
    bar_day = '0;
    bar_marker = '0;
    bar_last_seq = '0;
    bar_op = '0;
    bar_hi = '0;
    bar_lo = '0;
    bar_cl = '0;
    bar_first_idx = '0;
    fine_total = '0;
    coarse_total = '0;
    session_hi = '0;
    session_lo = '1;
  endfunction

  initial clear_bar_state();

  // Round P / d to the nearest integer: floor((2P + d) / (2d)), divisor 0 acts as 1
  function automatic logic [PriceW-1:0] scaled_price(logic [PriceW-1:0] p);
    logic [63:0] d;
    d = (price_div == '0) ? 64'd1 : 64'(price_div);
    return PriceW'(((64'(p) << 1) + d) / (d << 1));
  endfunction

  // Snapshot the open bar and advance the coarse counter
  function automatic coarse_bar_t close_coarse_bar(logic is_final);
    coarse_bar_t c;
    c.date       = bar_day;
    c.seq        = bar_last_seq;
    c.op_px      = bar_op;
    c.hi_px      = bar_hi;
    c.lo_px      = bar_lo;
    c.cl_px      = bar_cl;
    c.first_idx  = bar_first_idx;
    c.coarse_idx = coarse_total;
    c.total_hi   = is_final ? session_hi : '0;
    c.total_lo   = is_final ? session_lo : '0;
    c.stream_end = is_final;
    coarse_total = coarse_total + 1;
    return c;
  endfunction

  // Merge one accepted fine bar and queue the coarse bars it finishes
  function automatic void merge_fine_bar(fine_bar_t b);
    logic [PriceW-1:0] op, hi, lo, cl;
    int marker;
    int seq_span;
    logic new_bar;
    op = scaled_price(b.op_px);
    hi = scaled_price(b.hi_px);
    lo = scaled_price(b.lo_px);
    cl = scaled_price(b.cl_px);
    if (hi > session_hi) session_hi = hi;
    if (lo < session_lo) session_lo = lo;
    marker = int'($signed(bar_marker));
    seq_span = int'(b.seq) - marker;
    new_bar = !bar_open || (b.date != bar_day) || (seq_span > int'(seq_gap));
    if (new_bar) begin
      if (bar_open) coarse_expected.insert(coarse_expected.size(), close_coarse_bar(1'b0));
      bar_open = 1'b1;
      bar_day = b.date;
      bar_marker = MarkW'(b.seq) - SeqBackoff;
      bar_op = op;
      bar_hi = hi;
      bar_lo = lo;
      bar_first_idx = fine_total;
    end else begin
      if (hi > bar_hi) bar_hi = hi;
      if (lo < bar_lo) bar_lo = lo;
    end
    bar_cl = cl;
    bar_last_seq = b.seq;
    fine_total = fine_total + 1;
    if (b.last) begin
      coarse_expected.insert(coarse_expected.size(), close_coarse_bar(1'b1));
      clear_bar_state();
    end
  endfunction

  // Driver: present the next pending fine bar, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) merge_fine_bar(bar_on_wire);
      if (!in_valid_i || in_ready_o) begin
        if (bar_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bar_on_wire = bar_backlog.pop_front();
          in_valid_i    <= 1'b1;
          bar_date_i    <= bar_on_wire.date;
          time_seq_i    <= bar_on_wire.seq;
          open_price_i  <= bar_on_wire.op_px;
          high_price_i  <= bar_on_wire.hi_px;
          low_price_i   <= bar_on_wire.lo_px;
          close_price_i <= bar_on_wire.cl_px;
          final_item_i  <= bar_on_wire.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [PriceW-1:0] want,
                                      logic [PriceW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Monitor: compare each coarse bar with the oldest prediction, toggle ready
  always @(posedge clk_i) begin
    coarse_bar_t c;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (coarse_expected.size() == 0) begin
          $error("coarse bar with no prediction pending (date %0d seq %0d)",
                 out_date_o, out_seq_o);
          error_count++;
        end else begin
          c = coarse_expected.pop_front();
          check_field("out_date", PriceW'(c.date), PriceW'(out_date_o));
          check_field("out_seq", PriceW'(c.seq), PriceW'(out_seq_o));
          check_field("out_open", c.op_px, out_open_o);
          check_field("out_high", c.hi_px, out_high_o);
          check_field("out_low", c.lo_px, out_low_o);
          check_field("out_close", c.cl_px, out_close_o);
          check_field("first_fine_index", c.first_idx, first_fine_index_o);
          check_field("coarse_index", c.coarse_idx, coarse_index_o);
          check_field("overall_high", c.total_hi, overall_high_o);
          check_field("overall_low", c.total_lo, overall_low_o);
          check_field("stream_end", PriceW'(c.stream_end), PriceW'(stream_end_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void push_bar(logic [DateW-1:0] date, logic [SeqW-1:0] seq,
                                   logic [PriceW-1:0] op, logic [PriceW-1:0] hi,
                                   logic [PriceW-1:0] lo, logic [PriceW-1:0] cl,
                                   logic last);
    fine_bar_t b;
    b.date = date;
    b.seq = seq;
    b.op_px = op;
    b.hi_px = hi;
    b.lo_px = lo;
    b.cl_px = cl;
    b.last = last;
    bar_backlog.insert(bar_backlog.size(), b);
  endfunction

  // Mix full-range, small and near-maximum prices
  function automatic logic [PriceW-1:0] rand_price();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(0, 100000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom_range(0, 50_000_000);
    endcase
  endfunction

  // Queue mostly well-formed streams ending in a final bar, plus some noise
  task automatic queue_random_bars(int count);
    int made;
    int len;
    int k;
    logic [DateW-1:0] date;
    logic [SeqW-1:0] seq;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 30);
        date = DateW'($urandom_range(0, 99999999));
        seq = SeqW'($urandom());
        for (k = 0; k < len; k++) begin
          case ($urandom_range(9))
            0: date = DateW'($urandom_range(0, 99999999));
            1: seq = seq + SeqW'($urandom());
            2: seq = seq - SeqW'($urandom_range(1, 40));
            default: seq = seq + SeqW'($urandom_range(0, 6));
          endcase
          push_bar(date, seq, rand_price(), rand_price(), rand_price(), rand_price(),
                   k == len - 1);
          made++;
        end
      end else begin
        push_bar(DateW'($urandom_range(0, 99999999)), SeqW'($urandom()), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom_range(3) == 0);
        made++;
      end
    end
  endtask

  // Hold until every fine bar is taken and every coarse bar has come out,
  // then let a full item latency pass since the last bar may emit nothing
  task automatic drain();
    while (bar_backlog.size() != 0 || in_valid_i || coarse_expected.size() != 0)
      @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  // Write both registers back to back, valid held across the pair
  task automatic configure(logic [DivW-1:0] div, logic [DivW-1:0] gap);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SCALE_DIV;
    cfg_data_i  <= div;
    do @(posedge clk_i); while (!cfg_ready_o);
    price_div = div;
    cfg_index_i <= CFG_GAP_LIMIT;
    cfg_data_i  <= gap;
    do @(posedge clk_i); while (!cfg_ready_o);
    seq_gap = GapW'(gap);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [DivW-1:0] div, logic [DivW-1:0] gap, int idle_pct,
                           int stall_pct, int count);
    configure(div, gap);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_bars(count);
    drain();
  endtask

  // Stimulus sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bars at reset settings (divisor 1, gap 30)
    push_bar(12345678, 100, 0, 0, 0, 0, 1'b0);
    // distance equal to the gap limit merges
    push_bar(12345678, 125, '1, '1, '1, '1, 1'b0);
    // distance one past the gap limit starts a bar
    push_bar(12345678, 126, 1000, 2000, 1, 1500, 1'b0);
    // negative distance merges
    push_bar(12345678, 90, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 7, 1'b0);
    // date change
    push_bar(99999999, 90, 3, 4, 2, 3, 1'b0);
    // date change together with flush: two bars out
    push_bar(0, 32767, 10, 20, 5, 15, 1'b1);
    // single-bar stream right after a flush
    push_bar(0, 0, 5, 5, 5, 5, 1'b1);
    // marker below zero at sequence zero
    push_bar(0, 0, 0, 0, 0, 0, 1'b0);
    push_bar(0, 3, 1, 9, 1, 2, 1'b0);
    push_bar(0, 36, 4, 6, 3, 5, 1'b0);
    push_bar(0, 2, 8, 8, 8, 8, 1'b0);
    push_bar(1, 2, '1, 0, '1, 0, 1'b1);
    push_bar(99999999, 32767, 999, 1499, 500, 2500, 1'b0);
    push_bar(99999999, 32767, '1, '1, 0, '1, 1'b1);
    queue_random_bars(25);
    drain();

    // Random phases over settings and idling modes
    run_phase(1000, 30, 0, 0, 200);
    run_phase(65535, 0, 48, 0, 200);
    // zero divisor, gap written with the unused top bit set
    run_phase(0, 16'hFFFF, 0, 48, 200);
    run_phase(7, 12, 11, 11, 200);
    run_phase(DivW'($urandom_range(1, 65535)), DivW'($urandom_range(0, 64)), 48, 0, 200);
    run_phase(1, 0, 0, 48, 200);
    run_phase(65535, 32767, 11, 11, 200);
    run_phase(DivW'($urandom_range(1, 65535)), DivW'($urandom_range(0, 32767)), 0, 0, 200);

    if (error_count == 0) begin
      $display("ohlc_bar_aggregator_unit test passed");
    end else begin
      $display("ohlc_bar_aggregator_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("ohlc_bar_aggregator_unit test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ohlc_pkg.sv
sv/ohlc_div.sv
sv/ohlc_bar_aggregator_unit.sv
tb/sv/ohlc_bar_aggregator_unit_test.sv
